>>> src/qct_pkg.sv
// ----------------------------------------------------------------------------
// qct_pkg
// Shared types and constants of the quorum commit tracker: item and result
// payloads, the slot entry layout, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package qct_pkg;

    localparam int SLOTS_DEF = 16;

    localparam logic [3:0]  QUORUM_RST  = 4'd2;
    localparam logic [15:0] TIMEOUT_RST = 16'd30000;
    localparam logic [3:0]  ACKS_MAX    = 4'hF;
    localparam logic [15:0] AGE_MAX     = 16'hFFFF;
    localparam logic [31:0] INDEX_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_REG  = 2'd0,
        MODE_ACK  = 2'd1,
        MODE_TICK = 2'd2,
        MODE_NOP  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_QUORUM  = 2'd0,
        CFG_TIMEOUT = 2'd1,
        CFG_RSVD2   = 2'd2,
        CFG_RSVD3   = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MODW,
        ST_REG,
        ST_SCAN,
        ST_PREP,
        ST_ADV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] entry_index;
        logic [31:0] follower_index;
    } t_item;

    typedef struct packed {
        logic [31:0] commit_index;
        logic        commit_advanced;
    } t_result;

    typedef struct packed {
        logic [31:0] entry_index;
        logic [3:0]  acks;
        logic        committed;
        logic [15:0] age;
    } t_entry;

    typedef struct packed {
        logic [3:0]  quorum;
        logic [15:0] timeout;
    } t_alu_cfg;

endpackage

>>> src/quorum_commit_tracker.sv
// ----------------------------------------------------------------------------
// quorum_commit_tracker
// Tracks in-flight log entries in a direct-mapped slot table and maintains
// the quorum commit index.
// ----------------------------------------------------------------------------
// An item is taken when i_start is high and o_busy is low; its single result
// appears on o_result for exactly one cycle with o_res_strobe, the cycle after
// the item's last sequencer step, and must be captured then. A no-operation
// item goes straight to that last step. A registration waits for the slot
// index unit and then writes the new entry. A tick walks every slot through
// the slot RAM, one slot per cycle. An acknowledgement walks every slot once
// to count acks, then walks the commit chain one slot per cycle until it
// breaks or every slot has been visited; it skips the chain walk when the
// commit index is already at its maximum. The slot table lives in one RAM
// port pair with valid bits in flip-flops, so there is no clearing pass after
// reset. Configuration writes are always taken and must be issued only while
// the block is idle.
// ----------------------------------------------------------------------------
module quorum_commit_tracker #(
    parameter int SLOTS = qct_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  qct_pkg::t_item    i_item,
    output logic              o_res_strobe,
    output qct_pkg::t_result  o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    import qct_pkg::*;

    localparam int          SW      = $clog2(SLOTS);
    localparam logic [SW:0] SLOTS_C = (SW + 1)'(SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    t_state         r_state;
    t_state         n_state;
    t_mode          r_mode;
    logic [31:0]    r_lidx;
    logic [31:0]    r_midx;
    logic [31:0]    r_commit;
    logic [31:0]    r_old;
    logic [3:0]     r_quorum;
    logic [15:0]    r_timeout;
    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] r_free;
    logic [SW:0]    r_cnt;
    logic           r_pend;
    logic [SW-1:0]  r_pslot;
    logic [SW-1:0]  r_aslot;
    logic           r_strobe;
    logic           r_adv;

    logic           accept;
    logic           mod_start;
    logic [31:0]    mod_value;
    logic           mod_done;
    logic [SW-1:0]  mod_slot;

    logic           ram_we;
    logic [SW-1:0]  ram_waddr;
    t_entry         ram_wdata;
    logic           ram_re;
    logic [SW-1:0]  ram_raddr;
    t_entry         ram_rdata;

    t_alu_cfg       alu_cfg;
    t_entry         alu_entry;
    logic           alu_free;
    logic           alu_chain;
    logic           chain_ok;
    logic [31:0]    commit_inc;

    assign accept     = i_start && (r_state == ST_IDLE);
    assign commit_inc = r_commit + 32'd1;
    assign chain_ok   = r_pend && alu_chain && (r_commit != INDEX_MAX);

    // The slot of commit_index + 1 is worked out while the ack scan runs.
    assign mod_start = accept && ((i_item.mode == MODE_REG) || (i_item.mode == MODE_ACK));
    assign mod_value = (i_item.mode == MODE_REG) ? i_item.entry_index : commit_inc;

    qct_mod #(
        .SLOTS (SLOTS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (mod_value),
        .o_done  (mod_done),
        .o_slot  (mod_slot)
    );

    qct_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign alu_cfg.quorum  = r_quorum;
    assign alu_cfg.timeout = r_timeout;

    qct_slot_alu u_alu (
        .i_entry  (ram_rdata),
        .i_valid  (r_valid[r_pslot]),
        .i_ack    (r_mode == MODE_ACK),
        .i_match  (r_midx),
        .i_expect (commit_inc),
        .i_cfg    (alu_cfg),
        .o_entry  (alu_entry),
        .o_free   (alu_free),
        .o_chain  (alu_chain)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_mode'(i_item.mode))
                        MODE_REG:  n_state = ST_MODW;
                        MODE_ACK:  n_state = ST_SCAN;
                        MODE_TICK: n_state = ST_SCAN;
                        default:   n_state = ST_FIN;
                    endcase
                end
            end
            ST_MODW: begin
                if (mod_done) begin
                    n_state = ST_REG;
                end
            end
            ST_REG: n_state = ST_FIN;
            ST_SCAN: begin
                if ((r_cnt == SLOTS_C) && !r_pend) begin
                    n_state = (r_mode == MODE_ACK) ? ST_PREP : ST_FIN;
                end
            end
            ST_PREP: begin
                if (mod_done) begin
                    n_state = (r_commit == INDEX_MAX) ? ST_FIN : ST_ADV;
                end
            end
            ST_ADV: begin
                if (r_pend && !chain_ok) begin
                    n_state = ST_FIN;
                end else if ((r_cnt == SLOTS_C) && !r_pend) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // RAM port control.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_cnt[SW-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_pslot;
        ram_wdata = alu_entry;
        case (r_state)
            ST_SCAN: begin
                ram_re = (r_cnt < SLOTS_C);
                ram_we = r_pend;
            end
            ST_ADV: begin
                ram_re    = (r_cnt < SLOTS_C);
                ram_raddr = r_aslot;
            end
            ST_REG: begin
                ram_we                = 1'b1;
                ram_waddr             = mod_slot;
                ram_wdata.entry_index = r_lidx;
                ram_wdata.acks        = 4'd1;
                ram_wdata.committed   = 1'b0;
                ram_wdata.age         = '0;
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_commit  <= '0;
            r_quorum  <= QUORUM_RST;
            r_timeout <= TIMEOUT_RST;
            r_valid   <= '0;
            r_free    <= '0;
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;

            if (i_cfg_valid) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_QUORUM:  r_quorum  <= i_cfg_data[3:0];
                    CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    default:     r_quorum  <= r_quorum;
                endcase
            end

            if (accept) begin
                r_free <= '0;
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end

            if ((r_state == ST_SCAN) || (r_state == ST_ADV)) begin
                if (ram_re) begin
                    r_cnt <= r_cnt + (SW + 1)'(1);
                end
                r_pend <= ram_re;
            end

            if ((r_state == ST_SCAN) && r_pend && (r_mode == MODE_ACK)) begin
                r_free[r_pslot] <= alu_free;
            end

            if (r_state == ST_PREP) begin
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end

            if ((r_state == ST_ADV) && chain_ok) begin
                r_commit <= commit_inc;
            end

            if (r_state == ST_REG) begin
                r_valid[mod_slot] <= (r_quorum > 4'd1);
                if ((r_quorum <= 4'd1) && (r_lidx > r_commit)) begin
                    r_commit <= r_lidx;
                end
            end

            if (r_state == ST_FIN) begin
                r_strobe <= 1'b1;
                if (r_mode == MODE_ACK) begin
                    r_valid <= r_valid & ~r_free;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= t_mode'(i_item.mode);
            r_lidx <= i_item.entry_index;
            r_midx <= i_item.follower_index;
            r_old  <= r_commit;
        end
        if ((r_state == ST_SCAN) || (r_state == ST_ADV)) begin
            if (ram_re) begin
                r_pslot <= ram_raddr;
            end
        end
        if (r_state == ST_PREP) begin
            r_aslot <= mod_slot;
        end else if ((r_state == ST_ADV) && ram_re) begin
            r_aslot <= (r_aslot == LAST_SLOT) ? '0 : r_aslot + SW'(1);
        end
        if (r_state == ST_FIN) begin
            r_adv <= (r_commit > r_old);
        end
    end

    assign o_busy                   = (r_state != ST_IDLE);
    assign o_res_strobe             = r_strobe;
    assign o_result.commit_index    = r_commit;
    assign o_result.commit_advanced = r_adv;
    assign o_cfg_ready              = 1'b1;

    // A result strobe is never followed directly by another.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |=> !o_res_strobe)
        else $error("result strobe held for more than one cycle");

    // The commit index never moves down.
    a_commit_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_commit >= $past(r_commit))
        else $error("commit index decreased");

    // An accepted item keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("block not busy after taking an item");

    // An advance can only report a nonzero commit index.
    a_adv_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_result.commit_advanced) |-> (o_result.commit_index != 32'd0))
        else $error("advance reported with zero commit index");

endmodule

>>> src/qct_ram.sv
// ----------------------------------------------------------------------------
// qct_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module qct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/qct_mod.sv
// ----------------------------------------------------------------------------
// qct_mod
// Slot index unit: reduces a 32-bit log index modulo the slot count. A power
// of two count keeps the low index bits; any other count uses a reciprocal
// multiplication, a multiply-back subtraction, then one compare and subtract.
// ----------------------------------------------------------------------------
module qct_mod #(
    parameter int SLOTS = qct_pkg::SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [31:0]              i_value,
    output logic                     o_done,
    output logic [$clog2(SLOTS)-1:0] o_slot
);

    import qct_pkg::*;

    localparam int SW = $clog2(SLOTS);

    generate
        if ((SLOTS & (SLOTS - 1)) == 0) begin : g_pow2
            logic          r_done;
            logic [SW-1:0] r_slot;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else if (i_start) begin
                    r_done <= 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_slot <= i_value[SW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_slot = r_slot;
        end else begin : g_recip
            // The reciprocal is rounded down, so the quotient estimate is at
            // most one low and the partial remainder stays below twice SLOTS.
            localparam int          SHIFT   = 31 + SW;
            localparam logic [63:0] RECIP_W = (64'd1 << SHIFT) / 64'(SLOTS);
            localparam logic [31:0] RECIP   = RECIP_W[31:0];
            localparam logic [31:0] SLOTS_W = 32'(SLOTS);
            localparam logic [SW:0] SLOTS_C = (SW + 1)'(SLOTS);

            logic [2:0]    r_step;
            logic          r_done;
            logic [31:0]   r_val;
            logic [31:0]   r_quo;
            logic [SW:0]   r_part;
            logic [SW-1:0] r_rem;
            logic [63:0]   prod;
            logic [31:0]   back;

            assign prod = 64'(r_val) * 64'(RECIP);
            assign back = r_quo * SLOTS_W;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_step <= '0;
                    r_done <= 1'b0;
                end else if (i_start) begin
                    r_step <= 3'b001;
                    r_done <= 1'b0;
                end else begin
                    r_step <= {r_step[1:0], 1'b0};
                    if (r_step[2]) begin
                        r_done <= 1'b1;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_val <= i_value;
                end
                if (r_step[0]) begin
                    r_quo <= 32'(prod >> SHIFT);
                end
                if (r_step[1]) begin
                    r_part <= (SW + 1)'(r_val - back);
                end
                if (r_step[2]) begin
                    if (r_part >= SLOTS_C) begin
                        r_rem <= SW'(r_part - SLOTS_C);
                    end else begin
                        r_rem <= r_part[SW-1:0];
                    end
                end
            end

            assign o_done = r_done;
            assign o_slot = r_rem;
        end
    endgenerate

endmodule

>>> src/qct_slot_alu.sv
// ----------------------------------------------------------------------------
// qct_slot_alu
// Shared slot update unit: applies an acknowledgement or a tick to one slot
// entry, decides whether the slot is to be freed, and checks whether the slot
// continues the commit chain.
// ----------------------------------------------------------------------------
module qct_slot_alu (
    input  qct_pkg::t_entry   i_entry,
    input  logic              i_valid,
    input  logic              i_ack,
    input  logic [31:0]       i_match,
    input  logic [31:0]       i_expect,
    input  qct_pkg::t_alu_cfg i_cfg,
    output qct_pkg::t_entry   o_entry,
    output logic              o_free,
    output logic              o_chain
);

    import qct_pkg::*;

    logic [3:0] acks_inc;

    assign acks_inc = (i_entry.acks < ACKS_MAX) ? i_entry.acks + 4'd1 : i_entry.acks;

    always_comb begin
        o_entry = i_entry;
        if (i_ack) begin
            if (i_valid && !i_entry.committed && (i_entry.entry_index <= i_match)) begin
                o_entry.acks = acks_inc;
                if (acks_inc >= i_cfg.quorum) begin
                    o_entry.committed = 1'b1;
                end
            end
        end else if (i_valid && (i_entry.age != AGE_MAX)) begin
            o_entry.age = i_entry.age + 16'd1;
        end
    end

    assign o_free  = i_valid && (o_entry.committed || (i_entry.age > i_cfg.timeout));
    assign o_chain = i_valid && i_entry.committed && (i_entry.entry_index == i_expect);

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Quorum commit tracker testbench
// Drives registrations, follower acknowledgements, ticks and no-operation
// items through the start/busy port and checks every result against an
// in-bench prediction of the slot table and the commit index, or a row's
// fixed value. A directed table covers the basic flow, slot collisions,
// timeouts, repeat acks and reserved register writes. Bursty random traffic
// follows over several quorum and timeout settings. A closing table drives
// the commit index to its maximum and exercises quorums of one and zero.
// ----------------------------------------------------------------------------
module testbench;
    import qct_pkg::*;

    localparam int SLOT_COUNT = SLOTS_DEF;
    localparam int PHASE_ITEMS = 135;
    localparam logic [3:0] QUORUM_PLAN [8] = '{
        4'd3, 4'd1, 4'd15, 4'd2, 4'd5, 4'd1, 4'd4, 4'd2
    };
    localparam logic [15:0] TIMEOUT_PLAN [8] = '{
        16'd8, 16'd200, 16'hFFFF, 16'd1, 16'd30, 16'd1, 16'd3, 16'd30000
    };

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_item       item;
        t_cfg_reg    cfg_reg;
        logic [15:0] cfg_data;
        logic        known;
        t_result     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    t_item       i_item = '0;
    logic        o_res_strobe;
    t_result     o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    // Predicted state of the tracker.
    bit          slot_live [SLOT_COUNT] = '{default: 1'b0};
    t_entry      slot_tab [SLOT_COUNT];
    logic [31:0] commit_idx = '0;
    logic [3:0]  quorum_cfg = QUORUM_RST;
    logic [15:0] timeout_cfg = TIMEOUT_RST;

    t_result     expected_commits [$];
    t_result     due;
    int          mismatches = 0;
    t_row        opening [$];
    t_row        closing [$];

    quorum_commit_tracker dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_item       (i_item),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic int slot_of(input logic [31:0] idx);
        return int'(idx % SLOT_COUNT);
    endfunction

    function automatic t_result predict_commit(input t_item it);
        logic [31:0] prior_idx;
        logic [31:0] nxt;
        int          s;
        t_result     r;
        prior_idx = commit_idx;
        case (t_mode'(it.mode))
            MODE_REG: begin
                s = slot_of(it.entry_index);
                slot_live[s] = 1'b1;
                slot_tab[s] = '{entry_index: it.entry_index, acks: 4'd1, committed: 1'b0,
                                age: 16'd0};
                if (quorum_cfg <= 4'd1) begin
                    // The leader's own ack is a quorum; the commit index never moves down.
                    if (it.entry_index > commit_idx) commit_idx = it.entry_index;
                    slot_live[s] = 1'b0;
                end
            end
            MODE_ACK: begin
                for (s = 0; s < SLOT_COUNT; s++) begin
                    if (slot_live[s] && !slot_tab[s].committed &&
                        slot_tab[s].entry_index <= it.follower_index) begin
                        if (slot_tab[s].acks != ACKS_MAX) slot_tab[s].acks++;
                        if (slot_tab[s].acks >= quorum_cfg) slot_tab[s].committed = 1'b1;
                    end
                end
                for (int n = 0; n < SLOT_COUNT; n++) begin
                    if (commit_idx == INDEX_MAX) break;
                    nxt = commit_idx + 32'd1;
                    s = slot_of(nxt);
                    if (!slot_live[s] || slot_tab[s].entry_index != nxt ||
                        !slot_tab[s].committed) break;
                    commit_idx = nxt;
                end
                for (s = 0; s < SLOT_COUNT; s++) begin
                    if (slot_live[s] &&
                        (slot_tab[s].committed || slot_tab[s].age > timeout_cfg))
                        slot_live[s] = 1'b0;
                end
            end
            MODE_TICK: begin
                for (s = 0; s < SLOT_COUNT; s++) begin
                    if (slot_live[s] && slot_tab[s].age != AGE_MAX) slot_tab[s].age++;
                end
            end
            default: ;
        endcase
        r.commit_index = commit_idx;
        r.commit_advanced = commit_idx > prior_idx;
        return r;
    endfunction

    function automatic t_row op(input t_mode m, input logic [31:0] li, input logic [31:0] mi);
        t_row r;
        r = '0;
        r.kind = ROW_ITEM;
        r.item = '{mode: m, entry_index: li, follower_index: mi};
        return r;
    endfunction

    function automatic t_row chk(input t_mode m, input logic [31:0] li, input logic [31:0] mi,
                                 input logic [31:0] ci, input logic adv);
        t_row r;
        r = op(m, li, mi);
        r.known = 1'b1;
        r.want = '{commit_index: ci, commit_advanced: adv};
        return r;
    endfunction

    function automatic t_row setreg(input t_cfg_reg idx, input logic [15:0] data);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.cfg_reg = idx;
        r.cfg_data = data;
        return r;
    endfunction

    // Mostly well-formed traffic just above the commit point, plus stray indices.
    function automatic t_item random_item();
        t_item       it;
        int          pick;
        logic [31:0] stray;
        it.entry_index = $urandom;
        it.follower_index = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.mode = MODE_REG;
            it.entry_index = commit_idx + 32'd1 + $urandom_range(0, 23);
        end else if (pick < 75) begin
            it.mode = MODE_ACK;
            it.follower_index = commit_idx + $urandom_range(0, 23);
        end else if (pick < 85) begin
            it.mode = MODE_TICK;
        end else if (pick < 90) begin
            it.mode = MODE_NOP;
        end else begin
            case ($urandom_range(0, 3))
                0: stray = '0;
                1: stray = INDEX_MAX;
                default: stray = $urandom;
            endcase
            // A stray registration under a quorum of one would move the commit
            // index far away for the rest of the run.
            it.mode = (quorum_cfg > 4'd1 && pick < 95) ? MODE_REG : MODE_ACK;
            it.entry_index = stray;
            it.follower_index = stray;
        end
        return it;
    endfunction

    task automatic send_item(input t_item it, input logic known, input t_result want);
        t_result guess;
        i_cfg_valid <= 1'b0;
        i_start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_busy);
        guess = predict_commit(it);
        expected_commits.insert(expected_commits.size(), known ? want : guess);
    endtask

    task automatic pause(input int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [15:0] data);
        i_start <= 1'b0;
        while (expected_commits.size() != 0 || o_busy) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_QUORUM: quorum_cfg = data[3:0];
            CFG_TIMEOUT: timeout_cfg = data;
            default: ;
        endcase
    endtask

    task automatic walk(input t_row rows [$]);
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) write_reg(rows[i].cfg_reg, rows[i].cfg_data);
            else send_item(rows[i].item, rows[i].known, rows[i].want);
        end
    endtask

    task automatic random_traffic();
        int sent;
        int burst;
        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_QUORUM, {12'd0, QUORUM_PLAN[p]});
            write_reg(CFG_TIMEOUT, TIMEOUT_PLAN[p]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
                    send_item(random_item(), 1'b0, '0);
                    sent++;
                end
                if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 40));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) begin
            if (expected_commits.size() == 0) begin
                $error("unexpected result: commit_index %0h", o_result.commit_index);
                mismatches++;
            end else begin
                due = expected_commits.pop_front();
                if (o_result.commit_index !== due.commit_index) begin
                    $error("commit_index: expected %0h, got %0h",
                           due.commit_index, o_result.commit_index);
                    mismatches++;
                end
                if (o_result.commit_advanced !== due.commit_advanced) begin
                    $error("commit_advanced: expected %0b, got %0b",
                           due.commit_advanced, o_result.commit_advanced);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        opening = '{
            chk(MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0),
            chk(MODE_REG, 32'd1, 32'd0, 32'd0, 1'b0),
            chk(MODE_ACK, 32'd0, 32'd1, 32'd1, 1'b1),
            op(MODE_REG, 32'd2, 32'd0),
            op(MODE_REG, 32'd3, 32'd0),
            op(MODE_ACK, 32'd0, 32'd2),
            // Index 4 lands in the slot that index 20 holds and replaces it.
            op(MODE_REG, 32'd20, 32'd0),
            op(MODE_REG, 32'd4, 32'd0),
            op(MODE_ACK, 32'd0, 32'd4),
            op(MODE_REG, 32'd5, 32'd0),
            op(MODE_TICK, 32'd0, 32'd0),
            op(MODE_ACK, 32'd0, 32'd0),
            setreg(CFG_TIMEOUT, 16'd1),
            op(MODE_TICK, 32'd0, 32'd0),
            op(MODE_ACK, 32'd0, 32'd0),
            op(MODE_REG, 32'd6, 32'd0),
            op(MODE_ACK, 32'd0, 32'd6),
            setreg(CFG_QUORUM, 16'd3),
            setreg(CFG_TIMEOUT, 16'hFFFF),
            setreg(CFG_RSVD2, 16'd1),
            setreg(CFG_RSVD3, 16'd0),
            op(MODE_REG, 32'd5, 32'd0),
            op(MODE_ACK, 32'd0, 32'd5),
            op(MODE_ACK, 32'd0, 32'd5),
            op(MODE_REG, 32'hFFFF_FFFF, 32'd0),
            op(MODE_ACK, 32'd0, 32'hFFFF_FFFF),
            op(MODE_ACK, 32'd0, 32'hFFFF_FFFF)
        };
        closing = '{
            setreg(CFG_QUORUM, 16'd1),
            chk(MODE_REG, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1),
            chk(MODE_ACK, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0),
            chk(MODE_REG, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0),
            setreg(CFG_QUORUM, 16'd0),
            chk(MODE_REG, 32'd9, 32'd0, 32'hFFFF_FFFF, 1'b0),
            chk(MODE_TICK, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0),
            chk(MODE_NOP, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0)
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        walk(opening);
        random_traffic();
        walk(closing);
        i_start <= 1'b0;
        while (expected_commits.size() != 0) @(posedge i_clk);
        repeat (2 * SLOT_COUNT + 10) @(posedge i_clk);
        if (mismatches == 0 && expected_commits.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
